>>> rtl/cvos_pkg.sv
package cvos_pkg;

    // Field and state widths.
    localparam int LEVEL_W    = 14;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = LEVEL_W + FRAC_W;
    localparam int STEP_W     = 13;
    localparam int DELTA_W    = 32;
    localparam int VALUE_W    = 16;
    localparam int CFG_W      = 15;
    localparam int DAC_W      = 12;
    localparam int ACT_W      = 2;
    localparam int CH_W       = 2;
    localparam int CFG_ADDR_W = 3;

    // Register file layout: four offsets, then four slew times.
    localparam int REG_CH        = 4;
    localparam int CFG_SLEW_BASE = REG_CH;

    // Level clamp limit.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(16383);

    // Slew time to step count: ms / 6 as (ms * ceil(2^18 / 6)) >> 18, exact for 15-bit ms.
    localparam int                MS_PER_TICK = 6;
    localparam int                RECIP_SHIFT = 18;
    localparam int                RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_6    =
        RECIP_W'(((1 << RECIP_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK);
    localparam int                STEPS_MAX   = ((1 << CFG_W) - 1) / MS_PER_TICK;

    // Input actions.
    typedef enum logic [ACT_W-1:0] {
        ACT_SET  = 2'd0,
        ACT_TICK = 2'd1,
        ACT_SNAP = 2'd2
    } t_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_CALC,
        S_SET_START,
        S_DIV,
        S_TICK,
        S_EMIT
    } t_state;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/cvos_if.sv
// Input transaction channel.
interface cvos_in_if import cvos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic [CH_W-1:0]           channel;
    logic signed [VALUE_W-1:0] value;
    logic                      slew_enable;

    modport source (output valid, action, channel, value, slew_enable, input ready);
    modport sink   (input valid, action, channel, value, slew_enable, output ready);
endinterface

// Result transaction channel.
interface cvos_out_if import cvos_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             updated;
    logic             slewing;
    logic [DAC_W-1:0] dac_code_0;
    logic [DAC_W-1:0] dac_code_1;
    logic [DAC_W-1:0] dac_code_2;
    logic [DAC_W-1:0] dac_code_3;

    modport source (output valid, updated, slewing, dac_code_0, dac_code_1, dac_code_2,
                    dac_code_3, input ready);
    modport sink   (input valid, updated, slewing, dac_code_0, dac_code_1, dac_code_2,
                    dac_code_3, output ready);
endinterface

>>> rtl/cvos_div.sv
module cvos_div
    import cvos_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0] r_rem, n_rem;
    logic [STEP_W-1:0] r_dvs, n_dvs;
    logic [STEP_W:0]   w_trial;
    logic              w_fit;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    assign w_trial = {r_rem, r_quo[ACC_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ACC_W);
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? STEP_W'(w_trial - {1'b0, r_dvs}) : w_trial[STEP_W-1:0];
            n_quo = {r_quo[ACC_W-2:0], w_fit};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> rtl/cv_output_slew_engine.sv
// Control-voltage slew engine: CHANNELS levels of 14 bits, each ramping toward a target.
// Input channel i_in carries set, tick and snap transactions; o_res carries one result
// per tick (updated and slewing flags and four 12-bit DAC codes). Other actions give none.
// Offsets and slew times are written through i_cfg_we / i_cfg_addr / i_cfg_data; the user must
// do so only while idle, as the block does not enforce it. A set transaction passes through a
// calc and a start state; with slew on, the per-step delta comes from one shared radix-2 divider
// that retires one quotient bit per cycle over 30 bits. A tick walks the channels one per cycle
// through one accumulator adder, then loads its result in the emit state. A snap is done in idle.
// i_in.ready is high only while the sequencer is idle, one transaction at a time.
// The result sits in an output register; set and snap transactions are still taken while
// it waits. A tick whose result finds the register full waits until the receiver takes it.
// Reset (synchronous, active low) clears all levels, targets, ramps, configuration registers
// and the sequencer state to zero and empties the output register; no clearing pass is needed.
module cv_output_slew_engine
    import cvos_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    cvos_in_if.sink               i_in,
    cvos_out_if.source            o_res
);

    localparam int               IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    // Configuration registers.
    logic signed [CFG_W-1:0] r_offset [REG_CH];
    logic [CFG_W-1:0]        r_slew_ms [REG_CH];

    // Per-channel state.
    logic [LEVEL_W-1:0] r_level_now [CHANNELS], n_level_now [CHANNELS];
    logic [LEVEL_W-1:0] r_level_tgt [CHANNELS], n_level_tgt [CHANNELS];
    logic [STEP_W-1:0]  r_steps_left [CHANNELS], n_steps_left [CHANNELS];
    logic [DELTA_W-1:0] r_step_delta [CHANNELS], n_step_delta [CHANNELS];
    logic [ACC_W-1:0]   r_level_acc [CHANNELS], n_level_acc [CHANNELS];

    // Sequencer and the latched transaction.
    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [CH_W-1:0]           r_ch, n_ch;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic                      r_slew, n_slew;
    logic [LEVEL_W-1:0]        r_tgt, n_tgt;
    logic [STEP_W-1:0]         r_steps, n_steps;
    logic                      r_neg, n_neg;
    logic                      r_upd, n_upd;
    logic                      r_slw, n_slw;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic             r_out_upd, n_out_upd;
    logic             r_out_slw, n_out_slw;
    logic [DAC_W-1:0] r_out_dac [REG_CH], n_out_dac [REG_CH];

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                      w_accept;
    logic [IDX_W-1:0]          w_sel;
    logic signed [VALUE_W:0]   w_sum;
    logic [CFG_W+RECIP_W-1:0]  w_ms_prod;
    logic [STEP_W-1:0]         w_ms_steps;
    logic signed [LEVEL_W:0]   w_diff;
    logic [LEVEL_W-1:0]        w_mag;
    logic [STEP_W-1:0]         w_step_dec;
    logic [ACC_W-1:0]          w_acc_sum;
    logic [DAC_W-1:0]          w_dac [REG_CH];

    cvos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_sel     = IDX_W'(r_ch);

    // Offset sum is exact in 17 bits; the slew step count uses a reciprocal multiply.
    assign w_sum      = $signed({r_val[VALUE_W-1], r_val})
                      + $signed({{(VALUE_W + 1 - CFG_W){r_offset[r_ch][CFG_W-1]}}, r_offset[r_ch]});
    assign w_ms_prod  = r_slew_ms[r_ch] * RECIP_6;
    assign w_ms_steps = w_ms_prod[RECIP_SHIFT +: STEP_W];

    // Distance to the new target, as sign and magnitude for the divider.
    assign w_diff = $signed({1'b0, r_tgt}) - $signed({1'b0, r_level_now[w_sel]});
    assign w_mag  = w_diff[LEVEL_W] ? LEVEL_W'(-w_diff) : w_diff[LEVEL_W-1:0];

    // Shared step datapath for the channel walk.
    assign w_step_dec = r_steps_left[r_idx] - STEP_W'(1);
    assign w_acc_sum  = r_level_acc[r_idx] + r_step_delta[r_idx][ACC_W-1:0];

    // DAC codes; channels beyond the parameter read as zero.
    for (genvar g = 0; g < REG_CH; g++) begin : g_dac
        if (g < CHANNELS) begin : g_on
            assign w_dac[g] = r_level_now[g][LEVEL_W-1 -: DAC_W];
        end else begin : g_off
            assign w_dac[g] = '0;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_CH; i++) begin
                r_offset[i]  <= '0;
                r_slew_ms[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (int'(i_cfg_addr) < CFG_SLEW_BASE) begin
                r_offset[i_cfg_addr[CH_W-1:0]] <= i_cfg_data;
            end else begin
                r_slew_ms[i_cfg_addr[CH_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Next state, channel updates and the result register.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_ch         = r_ch;
        n_val        = r_val;
        n_slew       = r_slew;
        n_tgt        = r_tgt;
        n_steps      = r_steps;
        n_neg        = r_neg;
        n_upd        = r_upd;
        n_slw        = r_slw;
        n_level_now  = r_level_now;
        n_level_tgt  = r_level_tgt;
        n_steps_left = r_steps_left;
        n_step_delta = r_step_delta;
        n_level_acc  = r_level_acc;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_upd    = r_out_upd;
        n_out_slw    = r_out_slw;
        n_out_dac    = r_out_dac;
        w_div_req    = '{start: 1'b0, dividend: {w_mag, FRAC_W'(0)}, divisor: r_steps};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ch   = i_in.channel;
                    n_val  = i_in.value;
                    n_slew = i_in.slew_enable;
                    n_idx  = '0;
                    n_upd  = 1'b0;
                    n_slw  = 1'b0;
                    case (i_in.action)
                        ACT_SET: begin
                            if (int'(i_in.channel) < CHANNELS) begin
                                n_state = S_SET_CALC;
                            end
                        end
                        ACT_TICK: begin
                            n_state = S_TICK;
                        end
                        ACT_SNAP: begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                n_steps_left[i] = STEP_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Clamp the offset sum and work out the step count.
            S_SET_CALC: begin
                if (w_sum < 0) begin
                    n_tgt = '0;
                end else if (w_sum > $signed({3'b000, LEVEL_MAX})) begin
                    n_tgt = LEVEL_MAX;
                end else begin
                    n_tgt = w_sum[LEVEL_W-1:0];
                end
                n_steps = (w_ms_steps == '0) ? STEP_W'(1) : w_ms_steps;
                n_state = S_SET_START;
            end

            // Jump at once, or hand the scaled distance to the divider.
            S_SET_START: begin
                n_level_tgt[w_sel] = r_tgt;
                if (r_slew) begin
                    w_div_req.start = 1'b1;
                    n_neg           = w_diff[LEVEL_W];
                    n_state         = S_DIV;
                end else begin
                    n_steps_left[w_sel] = STEP_W'(1);
                    n_level_now[w_sel]  = r_tgt;
                    n_level_acc[w_sel]  = {r_tgt, FRAC_W'(0)};
                    n_state             = S_IDLE;
                end
            end

            // Load the ramp once the quotient is ready.
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_steps_left[w_sel] = r_steps;
                    n_step_delta[w_sel] = r_neg
                        ? (DELTA_W'(0) - DELTA_W'(w_div_rsp.quotient))
                        : DELTA_W'(w_div_rsp.quotient);
                    n_level_acc[w_sel]  = {r_level_now[w_sel], FRAC_W'(0)};
                    n_state             = S_IDLE;
                end
            end

            // Advance one channel per cycle.
            S_TICK: begin
                if (r_steps_left[r_idx] != '0) begin
                    n_steps_left[r_idx] = w_step_dec;
                    if (w_step_dec == '0) begin
                        n_level_now[r_idx] = r_level_tgt[r_idx];
                    end else begin
                        n_level_acc[r_idx] = w_acc_sum;
                        n_level_now[r_idx] = w_acc_sum[ACC_W-1 -: LEVEL_W];
                        n_slw              = 1'b1;
                    end
                    n_upd = 1'b1;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // Load the result once the output register is free.
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_upd   = r_upd;
                    n_out_slw   = r_slw;
                    n_out_dac   = w_dac;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_upd       <= 1'b0;
            r_slw       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_level_now[i]  <= '0;
                r_level_tgt[i]  <= '0;
                r_steps_left[i] <= '0;
                r_step_delta[i] <= '0;
                r_level_acc[i]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_upd        <= n_upd;
            r_slw        <= n_slw;
            r_out_valid  <= n_out_valid;
            r_level_now  <= n_level_now;
            r_level_tgt  <= n_level_tgt;
            r_steps_left <= n_steps_left;
            r_step_delta <= n_step_delta;
            r_level_acc  <= n_level_acc;
        end
        r_ch      <= n_ch;
        r_val     <= n_val;
        r_slew    <= n_slew;
        r_tgt     <= n_tgt;
        r_steps   <= n_steps;
        r_neg     <= n_neg;
        r_out_upd <= n_out_upd;
        r_out_slw <= n_out_slw;
        r_out_dac <= n_out_dac;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.updated    = r_out_upd;
    assign o_res.slewing    = r_out_slw;
    assign o_res.dac_code_0 = r_out_dac[0];
    assign o_res.dac_code_1 = r_out_dac[1];
    assign o_res.dac_code_2 = r_out_dac[2];
    assign o_res.dac_code_3 = r_out_dac[3];

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    // A new result is only loaded at the end of a channel walk.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result register loaded outside the emit state");

    // A ramp never holds more steps than the longest slew time allows.
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps_left[r_idx] <= STEP_W'(STEPS_MAX))
        else $error("step count beyond the longest slew");

    // An accepted tick starts its walk at the first channel.
    a_tick_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.action == ACT_TICK)) |=> ((r_state == S_TICK) && (r_idx == '0)))
        else $error("tick walk did not start at channel zero");

endmodule
